// File: hw/rtl/lablch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lablch_pkg
// Shared constants and the arctangent table of the Lab to LCh converter.
// ----------------------------------------------------------------------------
package lablch_pkg;

  // Default component width (signed Q8.8 a and b) and rotation count
  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ROTATION_STAGES_DEF = 16;

  // Rotation stages beyond this count are not run
  localparam int ATAN_TABLE_LEN = 24;

  // Angle accumulator is a count of 2^-32 turns
  localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [31:0] HUE_ROUND   = 32'h0000_8000;
  localparam logic [15:0] CHROMA_MAX  = 16'hFFFF;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] turn_atan(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h2000_0000;
      1:       val = 32'h12E4_051E;
      2:       val = 32'h09FB_385B;
      3:       val = 32'h0511_11D4;
      4:       val = 32'h028B_0D43;
      5:       val = 32'h0145_D7E1;
      6:       val = 32'h00A2_F61E;
      7:       val = 32'h0051_7C55;
      8:       val = 32'h0028_BE53;
      9:       val = 32'h0014_5F2F;
      10:      val = 32'h000A_2F98;
      11:      val = 32'h0005_17CC;
      12:      val = 32'h0002_8BE6;
      13:      val = 32'h0001_45F3;
      14:      val = 32'h0000_A2FA;
      15:      val = 32'h0000_517D;
      16:      val = 32'h0000_28BE;
      17:      val = 32'h0000_145F;
      18:      val = 32'h0000_0A30;
      19:      val = 32'h0000_0518;
      20:      val = 32'h0000_028C;
      21:      val = 32'h0000_0146;
      22:      val = 32'h0000_00A3;
      23:      val = 32'h0000_0051;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/lab_to_lch_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_to_lch_polar
// Lab to LCh pixel converter: chroma by a pipelined square root, hue by a
// pipelined CORDIC in vectoring mode, lightness and run end passed along.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one Lab pixel per item, tdata holds lightness,
//   a (green_red) and b (blue_yellow); tlast marks the last pixel of a run.
//   Output stream (out_*): one LCh pixel per item, tdata holds lightness,
//   chroma (Q8.8) and hue (fraction of a turn times 65536); tlast copied.
//   An accepted item passes stage A, stage B, stage C and the stage
//   chain to the output register, which drives out_tvalid.
//   The chain depth is set by the square root, one root bit per stage, and by
//   the CORDIC, one rotation per stage, which run side by side.
//   Throughput: one item per cycle unless stalled. All stages move together;
//   the output register takes a new item whenever it is empty or being
//   read, so a new item is accepted in the same cycle a waiting result is
//   taken. When the receiver holds out_tready low with a result waiting,
//   the whole pipeline holds and in_tready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; the block is
//   ready for input in the first cycle after reset.
// ----------------------------------------------------------------------------
module lab_to_lch_polar
  import lablch_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input item
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [15:0] lightness, then green_red, then blue_yellow, zero padded
  input  logic [((16 + 2 * COMPONENT_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                    in_tlast,   // run_end
  // Result item
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [15:0] lightness_out, [31:16] chroma, [47:32] hue
  output logic [47:0]             out_tdata,
  output logic                    out_tlast   // run_end_out
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int SE  = (ROTATION_STAGES < ATAN_TABLE_LEN) ? ROTATION_STAGES
                                                          : ATAN_TABLE_LEN;
  localparam int G   = (W > SE) ? W : SE;
  localparam int XW  = W + 19;   // CORDIC datapath, room for gain
  localparam int RW  = W + 2;    // square root remainder
  localparam int SW  = 2 * W;    // radicand

  // Pipeline advance: output empty or being taken
  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Stage A: unpack, magnitudes, CORDIC pre-rotation into the right half
  // --------------------------------------------------------------------------
  logic signed [W-1:0] a_in, b_in;
  logic [W-1:0]        ua_nxt, ub_nxt;
  logic signed [XW-1:0] xe, ye, x0_nxt, y0_nxt;
  logic [31:0]         ang0_nxt;

  assign a_in = in_tdata[16 +: W];
  assign b_in = in_tdata[16 + W +: W];

  always_comb begin
    ua_nxt = a_in[W-1] ? (~a_in + 1'b1) : a_in;
    ub_nxt = b_in[W-1] ? (~b_in + 1'b1) : b_in;
    xe = {{(XW - W - 16){a_in[W-1]}}, a_in, 16'h0000};
    ye = {{(XW - W - 16){b_in[W-1]}}, b_in, 16'h0000};
    if (a_in[W-1]) begin
      x0_nxt   = -xe;
      y0_nxt   = -ye;
      ang0_nxt = HALF_TURN;
    end else begin
      x0_nxt   = xe;
      y0_nxt   = ye;
      ang0_nxt = 32'h0000_0000;
    end
  end

  logic                 va_r;
  logic [15:0]          lt_a_r;
  logic                 last_a_r, zero_a_r;
  logic [W-1:0]         ua_a_r, ub_a_r;
  logic signed [XW-1:0] x_a_r, y_a_r;
  logic [31:0]          ang_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_a_r   <= in_tdata[15:0];
      last_a_r <= in_tlast;
      zero_a_r <= (a_in == '0) && (b_in == '0);
      ua_a_r   <= ua_nxt;
      ub_a_r   <= ub_nxt;
      x_a_r    <= x0_nxt;
      y_a_r    <= y0_nxt;
      ang_a_r  <= ang0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squares of |a| and |b|
  // --------------------------------------------------------------------------
  logic [SW-1:0] ua_ext, ub_ext;

  assign ua_ext = {{W{1'b0}}, ua_a_r};
  assign ub_ext = {{W{1'b0}}, ub_a_r};

  logic                 vb_r;
  logic [15:0]          lt_b_r;
  logic                 last_b_r, zero_b_r;
  logic [SW-1:0]        sqa_b_r, sqb_b_r;
  logic signed [XW-1:0] x_b_r, y_b_r;
  logic [31:0]          ang_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_b_r   <= lt_a_r;
      last_b_r <= last_a_r;
      zero_b_r <= zero_a_r;
      sqa_b_r  <= ua_ext * ua_ext;
      sqb_b_r  <= ub_ext * ub_ext;
      x_b_r    <= x_a_r;
      y_b_r    <= y_a_r;
      ang_b_r  <= ang_a_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: radicand a*a + b*b (fits 2W bits), feeds the stage chain
  // --------------------------------------------------------------------------
  logic                 vld_r  [0:G];
  logic [15:0]          lt_r   [0:G];
  logic                 last_r [0:G];
  logic                 zero_r [0:G];
  logic [SW-1:0]        rad_r  [0:G];
  logic [RW-1:0]        rem_r  [0:G];
  logic [W-1:0]         root_r [0:G];
  logic signed [XW-1:0] x_r    [0:G];
  logic signed [XW-1:0] y_r    [0:G];
  logic [31:0]          ang_r  [0:G];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_r[0]   <= lt_b_r;
      last_r[0] <= last_b_r;
      zero_r[0] <= zero_b_r;
      rad_r[0]  <= sqa_b_r + sqb_b_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      x_r[0]    <= x_b_r;
      y_r[0]    <= y_b_r;
      ang_r[0]  <= ang_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage chain: one root bit per stage below W, one rotation per stage below SE
  // --------------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < G; g++) begin : g_stage
      logic [RW-1:0]        rem_nxt;
      logic [W-1:0]         root_nxt;
      logic [SW-1:0]        rad_nxt;
      logic signed [XW-1:0] x_nxt, y_nxt;
      logic [31:0]          ang_nxt;

      // Square root digit: bring down two radicand bits, try 4q+1
      if (g < W) begin : g_sqrt
        logic [RW+1:0] part;
        logic [RW+1:0] trial;
        always_comb begin
          part  = {rem_r[g], rad_r[g][SW-1 -: 2]};
          trial = {2'b00, root_r[g], 2'b01};
          rad_nxt = {rad_r[g][SW-3:0], 2'b00};
          if (part >= trial) begin
            rem_nxt  = RW'(part - trial);
            root_nxt = {root_r[g][W-2:0], 1'b1};
          end else begin
            rem_nxt  = part[RW-1:0];
            root_nxt = {root_r[g][W-2:0], 1'b0};
          end
        end
      end else begin : g_sqrt_hold
        assign rem_nxt  = rem_r[g];
        assign root_nxt = root_r[g];
        assign rad_nxt  = rad_r[g];
      end

      // CORDIC vectoring micro-rotation, steer y toward zero
      if (g < SE) begin : g_rot
        always_comb begin
          if (!y_r[g][XW-1]) begin
            x_nxt   = x_r[g] + (y_r[g] >>> g);
            y_nxt   = y_r[g] - (x_r[g] >>> g);
            ang_nxt = ang_r[g] + turn_atan(g);
          end else begin
            x_nxt   = x_r[g] - (y_r[g] >>> g);
            y_nxt   = y_r[g] + (x_r[g] >>> g);
            ang_nxt = ang_r[g] - turn_atan(g);
          end
        end
      end else begin : g_rot_hold
        assign x_nxt   = x_r[g];
        assign y_nxt   = y_r[g];
        assign ang_nxt = ang_r[g];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g+1] <= 1'b0;
        end else if (en) begin
          vld_r[g+1] <= vld_r[g];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          lt_r[g+1]   <= lt_r[g];
          last_r[g+1] <= last_r[g];
          zero_r[g+1] <= zero_r[g];
          rad_r[g+1]  <= rad_nxt;
          rem_r[g+1]  <= rem_nxt;
          root_r[g+1] <= root_nxt;
          x_r[g+1]    <= x_nxt;
          y_r[g+1]    <= y_nxt;
          ang_r[g+1]  <= ang_nxt;
        end
      end
    end
  endgenerate

  // --------------------------------------------------------------------------
  // Final stage: round and saturate chroma, round hue (zero for a zero vector), output register
  // --------------------------------------------------------------------------
  logic [W:0]    chroma_full;
  logic [32:0]   chroma_wide;
  logic [15:0]   chroma_nxt;
  logic [31:0]   hue_sum;
  logic [15:0]   hue_nxt;
  logic [RW-1:0] root_cmp;

  always_comb begin
    root_cmp    = {2'b00, root_r[G]};
    // rem > root means the true root lies above root + 1/2
    chroma_full = {1'b0, root_r[G]} + {{W{1'b0}}, (rem_r[G] > root_cmp)};
    chroma_wide = {{(32 - W){1'b0}}, chroma_full};
    chroma_nxt  = (chroma_wide > {17'h0_0000, CHROMA_MAX}) ? CHROMA_MAX
                                                           : chroma_wide[15:0];
    hue_sum     = ang_r[G] + HUE_ROUND;
    hue_nxt     = zero_r[G] ? 16'h0000 : hue_sum[31:16];
  end

  logic [47:0] out_tdata_r;
  logic        out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_r[G];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {hue_nxt, chroma_nxt, lt_r[G]};
      out_tlast_r <= last_r[G];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// File: sim/tb_lab_to_lch_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lab_to_lch_polar
// Self-checking bench for the Lab to LCh converter. A driver feeds Lab pixels
// from a queue of pending items, a bit-exact polar-conversion predictor
// computes lightness, rounded chroma and CORDIC hue per accepted item, and a
// monitor compares every result item in order. Three phases vary the idling
// on both streams; the last one also holds the result side off long enough
// to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_lab_to_lch_polar;
  import lablch_pkg::*;

  localparam int CORDIC_STAGES = (ROTATION_STAGES_DEF < ATAN_TABLE_LEN) ?
                                 ROTATION_STAGES_DEF : ATAN_TABLE_LEN;
  localparam int PIPE_LATENCY  = CORDIC_STAGES + 4;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int MAX_REPORTS   = 10;

  // Angle step per rotation, in 2^-32 turns
  localparam logic [31:0] ATAN_TURN [0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct packed {
    logic [15:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    logic               run_end;
  } lab_pixel_t;

  typedef struct packed {
    logic [15:0] lightness;
    logic [15:0] chroma;
    logic [15:0] hue;
    logic        run_end;
  } lch_pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  lab_pixel_t pending_lab [$];
  lch_pixel_t expected_lch [$];
  int         mismatches = 0;
  int         send_idle_pct = 28;
  int         recv_idle_pct = 46;
  int         phase_no = 1;

  lab_to_lch_polar #(
    .COMPONENT_WIDTH (16),
    .ROTATION_STAGES (CORDIC_STAGES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Polar form of one Lab pixel: rounded magnitude and vectoring-CORDIC angle
  function automatic lch_pixel_t lab_to_lch(lab_pixel_t p);
    lch_pixel_t          r;
    longint signed       a_val, b_val, x, y, nx, ny;
    longint unsigned     mag_sq, root, trial;
    logic [31:0]         turns;
    a_val = $signed(p.green_red);
    b_val = $signed(p.blue_yellow);
    r.lightness = p.lightness;
    r.run_end   = p.run_end;
    // chroma: floor root bit by bit, then round to nearest
    mag_sq = a_val * a_val + b_val * b_val;
    root = 0;
    for (int k = 16; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= mag_sq) root = trial;
    end
    if (mag_sq - root * root > root) root++;
    r.chroma = (root > 64'd65535) ? CHROMA_MAX : root[15:0];
    // hue: fold the left half plane over, then rotate toward the +a axis
    x = a_val * 65536;
    y = b_val * 65536;
    turns = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      turns = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        turns = turns + ATAN_TURN[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        turns = turns - ATAN_TURN[i];
      end
      x = nx;
      y = ny;
    end
    turns = turns + HUE_ROUND;
    r.hue = (a_val == 0 && b_val == 0) ? 16'h0000 : turns[31:16];
    return r;
  endfunction

  task automatic add_lab(input logic [15:0] l, input logic [15:0] a,
                         input logic [15:0] b, input logic last);
    lab_pixel_t p;
    p.lightness   = l;
    p.green_red   = a;
    p.blue_yellow = b;
    p.run_end     = last;
    pending_lab.push_back(p);
  endtask

  // Wait until every queued item went in and every result came out
  task automatic drain();
    while (pending_lab.size() != 0 || in_tvalid || expected_lch.size() != 0)
      @(negedge clk);
  endtask

  // Driver: offers pending items, holds an item until it is taken
  always @(posedge clk) begin : drive_lab
    lab_pixel_t offered;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_lch.push_back(lab_to_lch(offered));
      if (!in_tvalid || in_tready) begin
        if (pending_lab.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered   = pending_lab.pop_front();
          in_tdata  <= {offered.blue_yellow, offered.green_red, offered.lightness};
          in_tlast  <= offered.run_end;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker; one long hold-off at the start of the last phase
  always @(posedge clk) begin : check_lch
    int         hold_left;
    bit         long_hold_done;
    lch_pixel_t want, got;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tlast};
        if (expected_lch.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result item: L=%h C=%h h=%h last=%b",
                     got.lightness, got.chroma, got.hue, got.run_end);
        end else begin
          want = expected_lch.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp L=%h C=%h h=%h last=%b, got L=%h C=%h h=%h last=%b",
                       want.lightness, want.chroma, want.hue, want.run_end,
                       got.lightness, got.chroma, got.hue, got.run_end);
          end
        end
      end
      if (phase_no == 3 && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus and phase sequencing
  initial begin : stimulus
    int          style;
    logic [15:0] a, b;
    logic [15:0] corner [6];
    corner = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero vector, axes, quadrants, extremes, half-turn fold
    add_lab(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_lab(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    add_lab(16'h1234, 16'h0100, 16'h0000, 1'b0);
    add_lab(16'h8000, 16'hFF00, 16'h0000, 1'b0);
    add_lab(16'h0001, 16'h0000, 16'h0100, 1'b0);
    add_lab(16'h7FFF, 16'h0000, 16'hFF00, 1'b1);
    add_lab(16'h5555, 16'h0001, 16'h0000, 1'b0);
    add_lab(16'hAAAA, 16'hFFFF, 16'h0000, 1'b0);
    add_lab(16'h00FF, 16'h0000, 16'h0001, 1'b0);
    add_lab(16'hFF00, 16'h0000, 16'hFFFF, 1'b0);
    add_lab(16'h0F0F, 16'h0001, 16'h0001, 1'b0);
    add_lab(16'hF0F0, 16'hFFFF, 16'hFFFF, 1'b1);
    add_lab(16'h3C3C, 16'h7FFF, 16'h7FFF, 1'b0);
    add_lab(16'hC3C3, 16'h8000, 16'h8000, 1'b0);
    add_lab(16'h6666, 16'h8000, 16'h7FFF, 1'b0);
    add_lab(16'h9999, 16'h7FFF, 16'h8000, 1'b0);
    add_lab(16'h2222, 16'h8000, 16'h0000, 1'b0);
    add_lab(16'hDDDD, 16'h0000, 16'h8000, 1'b0);
    add_lab(16'h4444, 16'h7FFF, 16'h0000, 1'b0);
    add_lab(16'hBBBB, 16'hFFFF, 16'h0001, 1'b1);
    add_lab(16'h1111, 16'h0300, 16'h0400, 1'b0);

    for (int ph = 1; ph <= 3; ph++) begin
      phase_no = ph;
      send_idle_pct = (ph == 1) ? 28 : (ph == 2) ? 46 : 0;
      recv_idle_pct = (ph == 1) ? 46 : (ph == 2) ? 28 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        style = $urandom_range(9);
        a = 16'($urandom);
        b = 16'($urandom);
        case (style)
          5, 6: begin    // small magnitudes, rounding and sign detail
            a = 16'($signed($urandom_range(16)) - 8);
            b = 16'($signed($urandom_range(16)) - 8);
          end
          7: begin       // on an axis
            if ($urandom_range(1)) a = '0; else b = '0;
          end
          8: begin       // extreme components
            a = corner[$urandom_range(5)];
            b = corner[$urandom_range(5)];
          end
          9: begin       // diagonals
            b = $urandom_range(1) ? a : 16'(-a);
          end
          default: ;
        endcase
        add_lab(16'($urandom), a, b, $urandom_range(7) == 0);
      end
      drain();
    end

    repeat (PIPE_LATENCY + 20) @(negedge clk);
    if (mismatches == 0 && expected_lch.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lablch_pkg.sv
hw/rtl/lab_to_lch_polar.sv
sim/tb_lab_to_lch_polar.sv
